### design/bmp_stream_writer_assert.svh
// Assertion macros shared by the BMP stream writer modules.
// Define ASSERT_OFF to compile the assertions out; needs no other file.
`ifndef BMP_STREAM_WRITER_ASSERT_SVH
`define BMP_STREAM_WRITER_ASSERT_SVH
`ifndef ASSERT_OFF
`define BSW_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BSW_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BSW_ASSERT(label, clk, rst_n, prop, msg)
`define BSW_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

### design/bsw_pkg.sv
// Types, codes and header helpers for the BMP stream writer.
// Depends on nothing; every module file imports it.
package bsw_pkg;

    localparam int DIM_W      = 14;
    localparam int DIM_LIMIT  = 16383;
    localparam int HDR_LEN    = 14 + 40;
    localparam int IDX_W      = 6;
    localparam int FIFO_DEPTH = 4;

    localparam logic [1:0] KIND_START   = 2'd0;
    localparam logic [1:0] KIND_PALETTE = 2'd1;
    localparam logic [1:0] KIND_PIXEL   = 2'd2;

    localparam logic [1:0] MODE_RGB24 = 2'd0;
    localparam logic [1:0] MODE_IDX8  = 2'd1;
    localparam logic [1:0] MODE_MONO  = 2'd2;
    localparam logic [1:0] MODE_RSVD  = 2'd3;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic [31:0] DIB_SIZE     = 32'd40;
    localparam logic [31:0] PLANES       = 32'd1;
    localparam logic [31:0] MAGIC_BM     = 32'h0000_4D42;
    localparam int          LUT_IDX8_LEN = 4 * 256;
    localparam int          LUT_MONO_LEN = 4 * 2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] pixel_value;
    } t_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
    } t_result;

    // Effective configuration as seen by the datapath.
    typedef struct packed {
        logic [1:0]       mode;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [31:0]      image_size;
        logic [31:0]      file_size;
    } t_cfg;

    // One unit of work for the byte emitter.
    typedef struct packed {
        logic            hdr;
        logic [2:0][7:0] data;
        logic [1:0]      ndata;
        logic [2:0]      nbytes;
        logic            frame_end;
    } t_job;

    function automatic logic [10:0] hdr_offset(input logic [1:0] mode);
        logic [10:0] off;
        case (mode)
            MODE_IDX8: off = 11'(HDR_LEN + LUT_IDX8_LEN);
            MODE_MONO: off = 11'(HDR_LEN + LUT_MONO_LEN);
            default:   off = 11'(HDR_LEN);
        endcase
        return off;
    endfunction

    // Byte idx of the 54-byte file and DIB header, all fields little endian.
    function automatic logic [7:0] hdr_byte(input logic [IDX_W-1:0] idx, input t_cfg cfg);
        logic [31:0]      word;
        logic [IDX_W-1:0] base;
        logic [1:0]       lane;
        logic [31:0]      bpp;
        logic [31:0]      colors;
        case (cfg.mode)
            MODE_IDX8: begin
                bpp    = 32'd8;
                colors = 32'd256;
            end
            MODE_MONO: begin
                bpp    = 32'd1;
                colors = 32'd2;
            end
            default: begin
                bpp    = 32'd24;
                colors = 32'd0;
            end
        endcase
        case (idx) inside
            [6'd0:6'd1]: begin
                word = MAGIC_BM;
                base = 6'd0;
            end
            [6'd2:6'd5]: begin
                word = cfg.file_size;
                base = 6'd2;
            end
            [6'd10:6'd13]: begin
                word = 32'(hdr_offset(cfg.mode));
                base = 6'd10;
            end
            [6'd14:6'd17]: begin
                word = DIB_SIZE;
                base = 6'd14;
            end
            [6'd18:6'd21]: begin
                word = 32'(cfg.width);
                base = 6'd18;
            end
            [6'd22:6'd25]: begin
                word = 32'(cfg.height);
                base = 6'd22;
            end
            [6'd26:6'd27]: begin
                word = PLANES;
                base = 6'd26;
            end
            [6'd28:6'd29]: begin
                word = bpp;
                base = 6'd28;
            end
            [6'd34:6'd37]: begin
                word = cfg.image_size;
                base = 6'd34;
            end
            [6'd46:6'd49]: begin
                word = colors;
                base = 6'd46;
            end
            [6'd50:6'd53]: begin
                word = colors;
                base = 6'd50;
            end
            default: begin
                word = 32'd0;
                base = idx;
            end
        endcase
        lane = 2'(idx - base);
        return word[{lane, 3'b000} +: 8];
    endfunction

endpackage

### design/bsw_cfg.sv
// Configuration registers of the BMP stream writer with the APB-style port.
// Also derives clamped geometry and the header sizes. Depends on bsw_pkg.
module bsw_cfg import bsw_pkg::*; #(
    parameter int MAX_DIM = 8192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    localparam int               DIM_CAP = (MAX_DIM > DIM_LIMIT) ? DIM_LIMIT : MAX_DIM;
    localparam logic [DIM_W-1:0] CAP_V   = DIM_W'(DIM_CAP);
    localparam int               RB_W    = DIM_W + 2;

    logic [1:0]       r_mode;
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic [31:0]      r_image_size;
    logic [31:0]      r_file_size;

    logic [1:0]         eff_mode;
    logic [DIM_W-1:0]   eff_width;
    logic [DIM_W-1:0]   eff_height;
    logic [RB_W-1:0]    row_data;
    logic [RB_W-1:0]    row_bytes;
    logic [29:0]        product;
    logic               wr_en;
    logic [1:0]         reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_RGB24;
            r_width  <= DIM_W'(1);
            r_height <= DIM_W'(1);
        end else if (wr_en) begin
            case (reg_idx)
                REG_MODE:   r_mode   <= pwdata[1:0];
                REG_WIDTH:  r_width  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: r_height <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MODE:   prdata = 32'(r_mode);
            REG_WIDTH:  prdata = 32'(r_width);
            REG_HEIGHT: prdata = 32'(r_height);
            default:    prdata = 32'd0;
        endcase
    end

    assign eff_mode   = (r_mode == MODE_RSVD) ? MODE_RGB24 : r_mode;
    assign eff_width  = (r_width == '0) ? DIM_W'(1) :
                        ((r_width > CAP_V) ? CAP_V : r_width);
    assign eff_height = (r_height == '0) ? DIM_W'(1) :
                        ((r_height > CAP_V) ? CAP_V : r_height);

    always_comb begin
        case (eff_mode)
            MODE_IDX8: row_data = RB_W'(eff_width);
            MODE_MONO: row_data = (RB_W'(eff_width) + RB_W'(7)) >> 3;
            default:   row_data = {1'b0, eff_width, 1'b0} + RB_W'(eff_width);
        endcase
    end

    assign row_bytes = (row_data + RB_W'(3)) & ~RB_W'(3);
    assign product   = 30'(row_bytes) * 30'(eff_height);

    // Sizes settle through the image size and then the file size register; the header needs them later.
    always_ff @(posedge i_clk) begin
        r_image_size <= 32'(product);
        r_file_size  <= r_image_size + 32'(hdr_offset(eff_mode));
    end

    assign o_cfg.mode       = eff_mode;
    assign o_cfg.width      = eff_width;
    assign o_cfg.height     = eff_height;
    assign o_cfg.image_size = r_image_size;
    assign o_cfg.file_size  = r_file_size;

endmodule

### design/bsw_front.sv
// Front end: accepts items, tracks row, column and 1-bit packing state,
// and turns each item that yields bytes into a byte job. Depends on bsw_pkg.
module bsw_front import bsw_pkg::*; #(
    parameter int MAX_DIM = 8192
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  t_cfg  i_cfg,
    input  logic  i_q_full,
    output logic  o_job_push,
    output t_job  o_job
);

    localparam int DIM_CAP = (MAX_DIM > DIM_LIMIT) ? DIM_LIMIT : MAX_DIM;
    localparam int CNT_W   = $clog2(DIM_CAP);
    localparam int CMP_W   = DIM_W + 1;

    logic [CNT_W-1:0] r_col;
    logic [CNT_W-1:0] r_row;
    logic [7:0]       r_acc;
    logic [2:0]       r_bits;

    logic [CNT_W-1:0] n_col;
    logic [CNT_W-1:0] n_row;
    logic [7:0]       n_acc;
    logic [2:0]       n_bits;

    logic             accept;
    logic [CNT_W:0]   col_inc;
    logic [CNT_W:0]   row_inc;
    logic             row_end;
    logic             frame_done;
    logic [3:0]       bits_inc;
    logic [7:0]       acc_shift;
    logic [DIM_W:0]   mono_sum;
    logic [1:0]       row_pad;
    t_job             job;

    assign accept     = i_push && !i_q_full;
    assign col_inc    = {1'b0, r_col} + 1'b1;
    assign row_inc    = {1'b0, r_row} + 1'b1;
    assign row_end    = CMP_W'(col_inc) >= CMP_W'(i_cfg.width);
    assign frame_done = CMP_W'(row_inc) >= CMP_W'(i_cfg.height);
    assign bits_inc   = {1'b0, r_bits} + 4'd1;
    assign acc_shift  = {r_acc[6:0], i_item.pixel_value[0]};
    assign mono_sum   = {1'b0, i_cfg.width} + (DIM_W+1)'(7);

    // Padding to the next multiple of four bytes.
    always_comb begin
        case (i_cfg.mode)
            MODE_IDX8: row_pad = 2'd0 - i_cfg.width[1:0];
            MODE_MONO: row_pad = 2'd0 - mono_sum[4:3];
            default:   row_pad = 2'd0 - 2'(i_cfg.width[1:0] + {i_cfg.width[0], 1'b0});
        endcase
    end

    always_comb begin
        job         = '0;
        n_col       = r_col;
        n_row       = r_row;
        n_acc       = r_acc;
        n_bits      = r_bits;
        case (i_item.kind)
            KIND_START: begin
                job.hdr = 1'b1;
                n_col   = '0;
                n_row   = '0;
                n_acc   = '0;
                n_bits  = '0;
            end
            KIND_PALETTE: begin
                if (i_cfg.mode != MODE_RGB24) begin
                    job.data   = {i_item.red, i_item.green, i_item.blue};
                    job.ndata  = 2'd3;
                    job.nbytes = 3'd4;
                end
            end
            KIND_PIXEL: begin
                case (i_cfg.mode)
                    MODE_IDX8: begin
                        job.data[0] = i_item.pixel_value;
                        job.ndata   = 2'd1;
                    end
                    MODE_MONO: begin
                        if (bits_inc == 4'd8) begin
                            job.data[0] = acc_shift;
                            job.ndata   = 2'd1;
                            n_acc       = '0;
                            n_bits      = '0;
                        end else begin
                            n_acc  = acc_shift;
                            n_bits = bits_inc[2:0];
                        end
                    end
                    default: begin
                        job.data  = {i_item.red, i_item.green, i_item.blue};
                        job.ndata = 2'd3;
                    end
                endcase
                if (row_end) begin
                    // A partial packed byte is flushed MSB aligned at row end.
                    if (i_cfg.mode == MODE_MONO && n_bits != 3'd0) begin
                        job.data[0] = n_acc << (3'd0 - n_bits);
                        job.ndata   = 2'd1;
                        n_acc       = '0;
                        n_bits      = '0;
                    end
                    job.nbytes = 3'(job.ndata) + 3'(row_pad);
                    n_col      = '0;
                    if (frame_done) begin
                        n_row         = '0;
                        job.frame_end = 1'b1;
                    end else begin
                        n_row = row_inc[CNT_W-1:0];
                    end
                end else begin
                    job.nbytes = 3'(job.ndata);
                    n_col      = col_inc[CNT_W-1:0];
                end
            end
            default: ;
        endcase
    end

    assign o_job      = job;
    assign o_job_push = accept && (job.hdr || job.nbytes != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_acc  <= '0;
            r_bits <= '0;
        end else if (accept) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_acc  <= n_acc;
            r_bits <= n_bits;
        end
    end

endmodule

### design/bsw_fifo.sv
// Short job queue between the front end and the byte emitter.
// Head is shown while not empty. Depends on bsw_pkg and the assertion header.
`include "bmp_stream_writer_assert.svh"
module bsw_fifo import bsw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_head
);

    localparam int               PTR_W   = $clog2(FIFO_DEPTH);
    localparam int               CNT_W   = $clog2(FIFO_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_V = CNT_W'(FIFO_DEPTH);

    t_job             r_entries [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en;

    assign o_full  = (r_count == DEPTH_V);
    assign o_valid = (r_count != '0);
    assign o_head  = r_entries[r_rd_ptr];
    assign wr_en   = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_entries[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(wr_en) - CNT_W'(i_pop);
        end
    end

    `BSW_ASSERT(a_ptr_count, i_clk, i_rst_n, (r_wr_ptr - r_rd_ptr) == PTR_W'(r_count), "queue pointers disagree with count")
    `BSW_ASSERT(a_no_underflow, i_clk, i_rst_n, i_pop |-> (r_count != '0), "job queue popped while empty")

endmodule

### design/bsw_back.sv
// Back end: walks the head job byte by byte into the result register.
// Depends on bsw_pkg and the assertion header.
`include "bmp_stream_writer_assert.svh"
module bsw_back import bsw_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_head_valid,
    input  t_job    i_head,
    input  t_cfg    i_cfg,
    input  logic    pop,
    output logic    o_pop,
    output logic    empty,
    output t_result o_result
);

    logic [IDX_W-1:0] r_idx;
    logic             r_out_valid;
    t_result          r_out;

    logic [IDX_W-1:0] idx_inc;
    logic             last_byte;
    logic             load;
    logic [7:0]       data_byte;
    logic [7:0]       cur_byte;

    assign idx_inc   = r_idx + IDX_W'(1);
    assign last_byte = i_head.hdr ? (r_idx == IDX_W'(HDR_LEN - 1)) :
                                    (idx_inc == IDX_W'(i_head.nbytes));
    assign data_byte = (r_idx < IDX_W'(i_head.ndata)) ? i_head.data[r_idx[1:0]] : 8'h00;
    assign cur_byte  = i_head.hdr ? hdr_byte(r_idx, i_cfg) : data_byte;
    assign load      = i_head_valid && (!r_out_valid || pop);
    assign o_pop     = load && last_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx <= last_byte ? '0 : idx_inc;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.out_byte  <= cur_byte;
            r_out.run_last  <= last_byte;
            r_out.frame_end <= last_byte && i_head.frame_end;
        end
    end

    assign empty    = !r_out_valid;
    assign o_result = r_out;

    `BSW_ASSERT(a_data_idx, i_clk, i_rst_n, (i_head_valid && !i_head.hdr) |-> (r_idx < IDX_W'(i_head.nbytes)), "byte index ran past data job")
    `BSW_ASSERT(a_idx_rewind, i_clk, i_rst_n, o_pop |=> (r_idx == '0), "byte index not rewound after job")
    `BSW_NEVER(a_end_last, i_clk, i_rst_n, r_out_valid && r_out.frame_end && !r_out.run_last, "frame end off the last byte of an item")

endmodule

### design/bmp_stream_writer.sv
// Top level of the BMP stream writer: APB-style registers, front end,
// job queue and byte emitter. Depends on bsw_pkg and all bsw_ modules.
//
// Items enter through a queue-style port: an item is taken at a clock edge
// with push high and full low. kind selects a start item (the 54-byte file
// and DIB header), a palette entry (B, G, R, 0) or a pixel (three, one or a
// packed eighth of a byte, plus row padding). Result bytes leave through a
// second queue-style port: the oldest byte sits on o_result while empty is
// low and is taken at an edge with pop high.
// An item's first byte passes through the job queue and the result register.
// The byte emitter sets the pace: one byte per cycle while pop is high, so
// a 24-bit pixel gives three bytes, a palette entry four and a header 54. A
// four-entry job queue lets new items enter while bytes still drain.
// When the receiver stalls, the result register holds its byte, the queue
// fills and full rises; nothing is dropped. Reset empties the queue and the
// result register, clears row, column and packing state and sets mode 0 with
// a 1 x 1 image. Header sizes are registered after a register write.
// Registers lie at byte addresses 0 (mode), 4 (width) and 8 (height).
module bmp_stream_writer import bsw_pkg::*; #(
    parameter int MAX_DIM = 8192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    input  t_item       i_item,
    output logic        full,
    input  logic        pop,
    output t_result     o_result,
    output logic        empty
);

    // Clamped configuration and the derived header sizes.
    t_cfg cfg;

    // Job handoff between the front end and the queue.
    logic job_push;
    t_job job;

    // Queue head and the pop from the byte emitter.
    logic q_full;
    logic q_valid;
    t_job q_head;
    logic q_pop;

    bsw_cfg #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The front end takes every item while the queue has room, including
    // items that produce no bytes; those only update the row state.
    bsw_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .i_cfg      (cfg),
        .i_q_full   (q_full),
        .o_job_push (job_push),
        .o_job      (job)
    );

    bsw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    // The emitter retires a job from the queue when its last byte is loaded.
    bsw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_valid),
        .i_head       (q_head),
        .i_cfg        (cfg),
        .pop          (pop),
        .o_pop        (q_pop),
        .empty        (empty),
        .o_result     (o_result)
    );

    assign full = q_full;

endmodule
